// ===== rtl/sorted_timer_queue_unit_macros.svh =====
// Assertion helpers for the sorted timer queue unit.
`ifndef SORTED_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMER_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stq: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stq: next-cycle check failed");

`endif

// ===== rtl/stq_pkg.sv =====
package stq_pkg;

  localparam int NUM_TIMERS_DEF = 16;

  localparam int ID_W   = 4;
  localparam int TICK_W = 32;
  localparam int LEFT_W = 31;

  localparam logic [1:0] ACT_ARM    = 2'd0;
  localparam logic [1:0] ACT_DISARM = 2'd1;
  localparam logic [1:0] ACT_SVC    = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FIRED = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // a lies strictly after b on the wrapping tick line
  function automatic logic tick_after(input logic [TICK_W-1:0] a,
                                     input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TICK_W-1];
  endfunction

endpackage

// ===== rtl/stq_ram.sv =====
module stq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_timer_queue_unit.sv =====
// Sorted timer queue: timers ordered by absolute expiry tick (wrap-aware).
// Input channel in_*: one transfer is one request. in_tuser carries the
// action (arm, disarm, service); in_tdata carries id, interval, repeat, now.
// Result channel out_*: exactly one result transfer per request. out_tuser
// carries the status; out_tdata carries fired id, ticks until due, head flag.
// One request is worked on at a time; in_tready is high only while idle.
// Slot order, expiry and reload period live in three RAMs with registered read.
// Removing a timer walks the order RAM entry by entry (read, check, compact);
// inserting reads each entry and its expiry and compares them until it finds
// the place or the end, then shifts the later entries up. A service first
// looks up the head (order read, expiry read, compare); a repeating head that
// fires is removed and reinserted; arming an armed slot removes it first.
// Reset (synchronous, active low) empties the queue and disarms every slot;
// the RAM contents need no clearing pass.
// A result waits in the output register while the receiver holds out_tready
// low; the next request is still taken and processed, then holds in its last
// step until the output register is free.
`include "sorted_timer_queue_unit_macros.svh"

module sorted_timer_queue_unit #(
  parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] timer_id, [35:4] interval, [36] repeat_req, [68:37] now
  input  logic [71:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] fired_timer, [34:4] ticks_until_due, [35] became_head
  output logic [39:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int TW = stq_pkg::TICK_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DROP_RD   = 4'd1;
  localparam logic [3:0] S_DROP_CHK  = 4'd2;
  localparam logic [3:0] S_PLACE_RD  = 4'd3;
  localparam logic [3:0] S_PLACE_EXP = 4'd4;
  localparam logic [3:0] S_PLACE_CHK = 4'd5;
  localparam logic [3:0] S_SVC_RD    = 4'd6;
  localparam logic [3:0] S_SVC_EXP   = 4'd7;
  localparam logic [3:0] S_SVC_CHK   = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  // unpack the request
  logic [stq_pkg::ID_W-1:0] in_id;
  logic [TW-1:0]            in_interval;
  logic                     in_rep;
  logic [TW-1:0]            in_now;
  logic [IW-1:0]            id_slot;
  logic                     id_ok;

  assign in_id       = in_tdata[3:0];
  assign in_interval = in_tdata[35:4];
  assign in_rep      = in_tdata[36];
  assign in_now      = in_tdata[68:37];
  assign id_slot     = IW'(in_id);
  assign id_ok       = 32'(in_id) < NUM_TIMERS;

  // control and payload registers
  logic [3:0]                state_r, state_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [NUM_TIMERS-1:0]     armed_r, armed_nxt;
  logic                      found_r, found_nxt;
  logic                      ins_r, ins_nxt;
  logic                      place_r, place_nxt;
  logic [IW-1:0]             slot_r, slot_nxt;
  logic [IW-1:0]             carry_r, carry_nxt;
  logic [IW-1:0]             cur_r, cur_nxt;
  logic [TW-1:0]             when_r, when_nxt;
  logic [TW-1:0]             now_r, now_nxt;
  logic [1:0]                status_r, status_nxt;
  logic [stq_pkg::ID_W-1:0]  fired_r, fired_nxt;
  logic [stq_pkg::LEFT_W-1:0] left_r, left_nxt;
  logic                      head_r, head_nxt;

  // output register
  logic                       out_load;
  logic                       ovalid_r, ovalid_nxt;
  logic [1:0]                 out_status_r;
  logic [stq_pkg::ID_W-1:0]   out_fired_r;
  logic [stq_pkg::LEFT_W-1:0] out_left_r;
  logic                       out_head_r;

  // RAM ports
  logic          ord_we;
  logic [IW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic          exp_we;
  logic [IW-1:0] exp_waddr, exp_raddr;
  logic [TW-1:0] exp_wdata, exp_rdata;
  logic          rel_we;
  logic [IW-1:0] rel_waddr;
  logic [TW-1:0] rel_wdata, rel_rdata;

  logic [CW-1:0] k_m1;
  logic [TW-1:0] arm_when;
  logic [TW-1:0] svc_left;
  logic [TW-1:0] reload_when;

  assign k_m1        = k_r - CW'(1);
  assign arm_when    = in_now + in_interval;
  assign svc_left    = exp_rdata - now_r;
  assign reload_when = exp_rdata + rel_rdata;

  stq_ram #(.WIDTH(IW), .DEPTH(NUM_TIMERS)) u_order (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  stq_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_expiry (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .raddr (exp_raddr),
    .rdata (exp_rdata)
  );

  // reload period is read at the same slot as the expiry
  stq_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_reload (
    .clk   (clk),
    .we    (rel_we),
    .waddr (rel_waddr),
    .wdata (rel_wdata),
    .raddr (exp_raddr),
    .rdata (rel_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    count_nxt  = count_r;
    armed_nxt  = armed_r;
    found_nxt  = found_r;
    ins_nxt    = ins_r;
    place_nxt  = place_r;
    slot_nxt   = slot_r;
    carry_nxt  = carry_r;
    cur_nxt    = cur_r;
    when_nxt   = when_r;
    now_nxt    = now_r;
    status_nxt = status_r;
    fired_nxt  = fired_r;
    left_nxt   = left_r;
    head_nxt   = head_r;
    out_load   = 1'b0;
    ord_we     = 1'b0;
    ord_waddr  = '0;
    ord_wdata  = '0;
    ord_raddr  = '0;
    exp_we     = 1'b0;
    exp_waddr  = '0;
    exp_wdata  = '0;
    exp_raddr  = '0;
    rel_we     = 1'b0;
    rel_waddr  = '0;
    rel_wdata  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          now_nxt    = in_now;
          status_nxt = stq_pkg::ST_DONE;
          fired_nxt  = '0;
          left_nxt   = '0;
          head_nxt   = 1'b0;
          k_nxt      = '0;
          found_nxt  = 1'b0;
          ins_nxt    = 1'b0;
          place_nxt  = 1'b0;
          slot_nxt   = id_slot;
          state_nxt  = S_OUT;
          unique case (in_tuser)
            stq_pkg::ACT_ARM: begin
              if (id_ok) begin
                // store period and new expiry up front; an armed slot is dropped from the queue first
                rel_we    = 1'b1;
                rel_waddr = id_slot;
                rel_wdata = in_rep ? in_interval : '0;
                exp_we    = 1'b1;
                exp_waddr = id_slot;
                exp_wdata = arm_when;
                when_nxt  = arm_when;
                place_nxt = 1'b1;
                state_nxt = armed_r[id_slot] ? S_DROP_RD : S_PLACE_RD;
              end
            end
            stq_pkg::ACT_DISARM: begin
              if (id_ok && armed_r[id_slot]) begin
                state_nxt = S_DROP_RD;
              end
            end
            stq_pkg::ACT_SVC: begin
              if (count_r == '0) begin
                status_nxt = stq_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_SVC_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_DROP_RD: begin
        if (k_r == count_r) begin
          armed_nxt[slot_r] = 1'b0;
          if (found_r) begin
            count_nxt = count_r - CW'(1);
          end
          k_nxt     = '0;
          state_nxt = place_r ? S_PLACE_RD : S_OUT;
        end else begin
          ord_raddr = k_r[IW-1:0];
          state_nxt = S_DROP_CHK;
        end
      end

      S_DROP_CHK: begin
        // compact: every entry after the removed one moves down by one
        if (ord_rdata == slot_r) begin
          found_nxt = 1'b1;
        end else if (found_r) begin
          ord_we    = 1'b1;
          ord_waddr = k_m1[IW-1:0];
          ord_wdata = ord_rdata;
        end
        k_nxt     = k_r + CW'(1);
        state_nxt = S_DROP_RD;
      end

      S_PLACE_RD: begin
        if (k_r == count_r) begin
          ord_we    = 1'b1;
          ord_waddr = k_r[IW-1:0];
          ord_wdata = ins_r ? carry_r : slot_r;
          if (!ins_r) begin
            head_nxt = (k_r == '0) && (status_r == stq_pkg::ST_DONE);
          end
          count_nxt         = count_r + CW'(1);
          armed_nxt[slot_r] = 1'b1;
          state_nxt         = S_OUT;
        end else begin
          ord_raddr = k_r[IW-1:0];
          state_nxt = S_PLACE_EXP;
        end
      end

      S_PLACE_EXP: begin
        if (ins_r) begin
          // shift up: write the carried id, carry the displaced one
          ord_we    = 1'b1;
          ord_waddr = k_r[IW-1:0];
          ord_wdata = carry_r;
          carry_nxt = ord_rdata;
          k_nxt     = k_r + CW'(1);
          state_nxt = S_PLACE_RD;
        end else begin
          exp_raddr = ord_rdata;
          cur_nxt   = ord_rdata;
          state_nxt = S_PLACE_CHK;
        end
      end

      S_PLACE_CHK: begin
        if (stq_pkg::tick_after(exp_rdata, when_r)) begin
          ord_we    = 1'b1;
          ord_waddr = k_r[IW-1:0];
          ord_wdata = slot_r;
          carry_nxt = cur_r;
          ins_nxt   = 1'b1;
          head_nxt  = (k_r == '0) && (status_r == stq_pkg::ST_DONE);
        end
        k_nxt     = k_r + CW'(1);
        state_nxt = S_PLACE_RD;
      end

      S_SVC_RD: begin
        ord_raddr = '0;
        state_nxt = S_SVC_EXP;
      end

      S_SVC_EXP: begin
        exp_raddr = ord_rdata;
        slot_nxt  = ord_rdata;
        state_nxt = S_SVC_CHK;
      end

      S_SVC_CHK: begin
        if (stq_pkg::tick_after(exp_rdata, now_r)) begin
          status_nxt = stq_pkg::ST_WAIT;
          left_nxt   = svc_left[stq_pkg::LEFT_W-1:0];
          state_nxt  = S_OUT;
        end else begin
          // pop the head, reinsert one period later if it repeats
          status_nxt = stq_pkg::ST_FIRED;
          fired_nxt  = stq_pkg::ID_W'(slot_r);
          when_nxt   = reload_when;
          place_nxt  = (rel_rdata != '0);
          exp_we     = (rel_rdata != '0);
          exp_waddr  = slot_r;
          exp_wdata  = reload_when;
          k_nxt      = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_DROP_RD;
        end
      end

      S_OUT: begin
        // hold until the output register is free or being emptied
        if (!ovalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ovalid_nxt = out_load || (ovalid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      armed_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      armed_r  <= armed_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    found_r  <= found_nxt;
    ins_r    <= ins_nxt;
    place_r  <= place_nxt;
    slot_r   <= slot_nxt;
    carry_r  <= carry_nxt;
    cur_r    <= cur_nxt;
    when_r   <= when_nxt;
    now_r    <= now_nxt;
    status_r <= status_nxt;
    fired_r  <= fired_nxt;
    left_r   <= left_nxt;
    head_r   <= head_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_fired_r  <= fired_r;
      out_left_r   <= left_r;
      out_head_r   <= head_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0, out_head_r, out_left_r, out_fired_r};

  // a stalled result holds steady
  `STQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // queue fill never passes the slot count
  `STQ_ASSERT_IMPL(a_count_max, 1'b1, 32'(count_r) <= NUM_TIMERS)
  // between requests the number of armed slots equals the queue fill
  `STQ_ASSERT_IMPL(a_count_armed, in_tready, $countones(armed_r) == 32'(count_r))
  // a taken request closes the input side on the next cycle
  `STQ_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready)

endmodule
